/* rtl/nru_pkg.sv */
// Shared constants and types for the NRU page replacement unit.
package nru_pkg;

    localparam int VIRT_ADDR_BITS = 16;
    localparam int PHYS_ADDR_BITS = 10;
    localparam int MIN_SHIFT      = 5;
    localparam int VPN_W          = VIRT_ADDR_BITS - MIN_SHIFT;
    localparam int FRAME_W        = PHYS_ADDR_BITS - MIN_SHIFT;
    localparam int NUM_PAGES      = 1 << VPN_W;
    localparam int FRAME_CNT      = 1 << FRAME_W;
    localparam int CNT_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_PERIOD = 2'd1;

    // One page table entry: valid flag above the frame number.
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_pte;

    // Access to the page table memory.
    typedef struct packed {
        logic             we;
        logic [VPN_W-1:0] addr;
        t_pte             wdata;
    } t_pt_req;

endpackage

/* rtl/nru_pt_ram.sv */
// Page table memory: one entry per virtual page, one port, registered read.
module nru_pt_ram
    import nru_pkg::*;
(
    input  logic    i_clk,
    input  t_pt_req i_req,
    output t_pte    o_rdata
);

    t_pte r_mem [NUM_PAGES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

/* rtl/nru_page_replacement.sv */
// Top level of the NRU page replacement unit: sequencer, frame table and counters.
//
// One access is taken when start is high and busy is low; its single result
// appears on the o_ result ports, marked by o_done, which is high for exactly
// one cycle and cannot be held off. A hit passes through the read, lookup and
// done states. A fault that finds a free frame scans from frame 0 to the
// lowest free frame and loads it; a fault that must evict scans every frame
// that the current page size provides (32, 16 or 8), reads the victim's page
// number, evicts that page and loads. Busy drops in the strobe cycle, so the
// next access can be taken at the edge that ends it. The frame scan looks at
// one frame per cycle through a single class compare, and the single port of
// the page table memory takes the eviction and the load in separate cycles.
// After reset the page table is swept clear, one entry a cycle, over all 2048
// entries; busy stays high meanwhile, while configuration beats are taken at
// any time (o_cfg_ready is always high). The referenced bits are cleared after
// every clearing interval of accesses, and o_ref_cleared marks the access after
// which that happened. o_fault_total counts faults and saturates.
module nru_page_replacement
    import nru_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Access channel.
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          i_vaddr,
    input  logic                 i_func,
    // Result channel.
    output logic                 o_done,
    output logic                 o_fault,
    output logic [FRAME_W-1:0]   o_frame_num,
    output logic                 o_evicted,
    output logic [VPN_W-1:0]     o_evicted_page,
    output logic [CNT_W-1:0]     o_fault_total,
    output logic                 o_ref_cleared,
    // Configuration channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LOOKUP,
        S_SCAN,
        S_VICT,
        S_EVICT,
        S_LOAD,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [2:0]       r_page_shift;
    logic [CNT_W-1:0] r_clear_period;

    // Per-access working registers.
    logic [VPN_W-1:0]   r_vpn;
    logic               r_wr;
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] r_scan_idx;
    logic [FRAME_W-1:0] r_best_idx;
    logic [2:0]         r_min_class;
    logic [VPN_W-1:0]   r_clr_idx;

    // Frame status bits and counters.
    logic [FRAME_CNT-1:0] r_frame_used;
    logic [FRAME_CNT-1:0] r_frame_ref;
    logic [FRAME_CNT-1:0] r_frame_mod;
    logic [CNT_W-1:0]     r_access_cnt;
    logic [CNT_W-1:0]     r_fault_cnt;

    // Result registers.
    logic               r_done;
    logic               r_fault;
    logic [FRAME_W-1:0] r_frame_num;
    logic               r_evicted;
    logic [VPN_W-1:0]   r_evicted_page;
    logic               r_ref_cleared;

    // Frame-to-page memory; its read output is used only at the victim frame.
    logic [VPN_W-1:0] r_frame_page [FRAME_CNT];
    logic [VPN_W-1:0] r_fp_rdata;

    t_pt_req pt_req;
    t_pte    pt_rdata;

    logic [1:0]         eff_shift;
    logic [VPN_W-1:0]   in_vpn;
    logic [FRAME_W-1:0] last_frame;
    logic [2:0]         scan_class;
    logic               scan_better;
    logic [FRAME_W-1:0] victim_idx;
    logic [CNT_W-1:0]   access_next;
    logic               accept;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Shift code relative to the smallest page size; values below 5 act as 5.
    always_comb begin
        if (r_page_shift < 3'(MIN_SHIFT)) begin
            eff_shift = 2'd0;
        end else begin
            eff_shift = 2'(r_page_shift - 3'(MIN_SHIFT));
        end
    end

    // Page number and highest frame index for the current page size.
    always_comb begin
        unique case (eff_shift)
            2'd0: begin
                in_vpn     = i_vaddr[15:5];
                last_frame = 5'd31;
            end
            2'd1: begin
                in_vpn     = {1'b0, i_vaddr[15:6]};
                last_frame = 5'd15;
            end
            default: begin
                in_vpn     = {2'b00, i_vaddr[15:7]};
                last_frame = 5'd7;
            end
        endcase
    end

    // The shared compare unit: class of the frame under the scan pointer
    // against the best class seen so far.
    assign scan_class  = {1'b0, r_frame_ref[r_scan_idx], r_frame_mod[r_scan_idx]};
    assign scan_better = r_frame_used[r_scan_idx] && (scan_class < r_min_class);
    assign victim_idx  = scan_better ? r_scan_idx : r_best_idx;
    assign access_next = r_access_cnt + 1'b1;

    // Page table port: the clearing sweep, lookups, evictions and loads.
    always_comb begin
        pt_req.we    = 1'b0;
        pt_req.addr  = r_vpn;
        pt_req.wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                pt_req.we   = 1'b1;
                pt_req.addr = r_clr_idx;
            end
            S_EVICT: begin
                pt_req.we   = 1'b1;
                pt_req.addr = r_fp_rdata;
            end
            S_LOAD: begin
                pt_req.we          = 1'b1;
                pt_req.wdata.valid = 1'b1;
                pt_req.wdata.frame = r_frame;
            end
            default: begin
                pt_req.we = 1'b0;
            end
        endcase
    end

    nru_pt_ram u_pt_ram (
        .i_clk   (i_clk),
        .i_req   (pt_req),
        .o_rdata (pt_rdata)
    );

    // Frame-to-page memory: written on a load, read at the chosen frame.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_frame_page[r_frame] <= r_vpn;
        end
        r_fp_rdata <= r_frame_page[r_frame];
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift   <= 3'(MIN_SHIFT);
            r_clear_period <= 16'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_PAGE_SHIFT) begin
                r_page_shift <= i_cfg_data[2:0];
            end else if (i_cfg_index == CFG_CLEAR_PERIOD) begin
                r_clear_period <= i_cfg_data;
            end
        end
    end

    // Sequencer with frame status, counters and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_frame_used  <= '0;
            r_frame_ref   <= '0;
            r_frame_mod   <= '0;
            r_access_cnt  <= '0;
            r_fault_cnt   <= '0;
            r_done        <= 1'b0;
            r_fault       <= 1'b0;
            r_evicted     <= 1'b0;
            r_ref_cleared <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == VPN_W'(NUM_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_vpn          <= in_vpn;
                        r_wr           <= i_func;
                        r_fault        <= 1'b0;
                        r_evicted      <= 1'b0;
                        r_evicted_page <= '0;
                        r_state        <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOOKUP;
                end
                S_LOOKUP: begin
                    if (pt_rdata.valid) begin
                        r_frame                     <= pt_rdata.frame;
                        r_frame_ref[pt_rdata.frame] <= 1'b1;
                        if (r_wr) begin
                            r_frame_mod[pt_rdata.frame] <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_fault <= 1'b1;
                        if (r_fault_cnt != '1) begin
                            r_fault_cnt <= r_fault_cnt + 1'b1;
                        end
                        r_scan_idx  <= '0;
                        r_best_idx  <= '0;
                        r_min_class <= 3'd4;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    priority if (!r_frame_used[r_scan_idx]) begin
                        // Lowest free frame found: no eviction.
                        r_frame <= r_scan_idx;
                        r_state <= S_LOAD;
                    end else if (r_scan_idx == last_frame) begin
                        r_frame <= victim_idx;
                        r_state <= S_VICT;
                    end else begin
                        if (scan_better) begin
                            r_best_idx  <= r_scan_idx;
                            r_min_class <= scan_class;
                        end
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                S_VICT: begin
                    // The victim's page number is read out during this cycle.
                    r_state <= S_EVICT;
                end
                S_EVICT: begin
                    r_evicted      <= 1'b1;
                    r_evicted_page <= r_fp_rdata;
                    r_state        <= S_LOAD;
                end
                S_LOAD: begin
                    r_frame_used[r_frame] <= 1'b1;
                    r_frame_ref[r_frame]  <= 1'b1;
                    r_frame_mod[r_frame]  <= r_wr;
                    r_state               <= S_DONE;
                end
                S_DONE: begin
                    if (access_next == r_clear_period) begin
                        r_access_cnt  <= '0;
                        r_frame_ref   <= '0;
                        r_ref_cleared <= 1'b1;
                    end else begin
                        r_access_cnt  <= access_next;
                        r_ref_cleared <= 1'b0;
                    end
                    r_frame_num <= r_frame;
                    r_done      <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_fault        = r_fault;
    assign o_frame_num    = r_frame_num;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_evicted_page;
    assign o_fault_total  = r_fault_cnt;
    assign o_ref_cleared  = r_ref_cleared;

`ifndef SYNTHESIS
    // An eviction only ever happens on a fault.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_fault || !o_evicted))
        else $error("eviction reported without a fault");

    // A hit leaves the fault count where it was.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP && pt_rdata.valid) |=> $stable(r_fault_cnt))
        else $error("fault count moved on a hit");

    // The scan pointer never leaves the frames of the current page size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_idx <= last_frame))
        else $error("frame scan ran past the last frame");

    // A result is reported only by the final step of an access.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_DONE))
        else $error("result strobe outside the final step");
`endif

endmodule
